// ===== hdl/fpps_pkg.sv =====
// shared types and constants for the frenet polynomial path sampler
// used by the controller, the datapath and the top level
package fpps_pkg;

   localparam int unsigned CfgWidth = 24;
   localparam int unsigned Q30Shift = 30;
   localparam logic [31:0] Q30One = 32'h4000_0000;

   localparam logic [1:0] RegTimeHorizon    = 2'd0;
   localparam logic [1:0] RegLateralHorizon = 2'd1;
   localparam logic [1:0] RegSampleInterval = 2'd2;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_CHECK  = 11'b00000000010,
      ST_DIV    = 11'b00000000100,
      ST_POLY1  = 11'b00000001000,
      ST_POLY2  = 11'b00000010000,
      ST_POLY3  = 11'b00000100000,
      ST_POLY4  = 11'b00001000000,
      ST_POLY5  = 11'b00010000000,
      ST_POLY6  = 11'b00100000000,
      ST_POLY7  = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic poly1;
      logic poly2;
      logic poly3;
      logic poly4;
      logic poly5;
      logic poly6;
      logic poly7;
      logic emit;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic is_final;
      logic div_done;
      logic out_busy;
   } sts_type;

endpackage

// ===== hdl/fpps_ctrl.sv =====
// sequencing controller for the frenet path sampler
// depends on fpps_pkg
module fpps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpps_pkg::sts_type sts,
   output fpps_pkg::cmd_type cmd
);
   import fpps_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.stop) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_POLY1;
         end
         ST_POLY1: begin cmd.poly1 = 1'b1; state_in = ST_POLY2; end
         ST_POLY2: begin cmd.poly2 = 1'b1; state_in = ST_POLY3; end
         ST_POLY3: begin cmd.poly3 = 1'b1; state_in = ST_POLY4; end
         ST_POLY4: begin cmd.poly4 = 1'b1; state_in = ST_POLY5; end
         ST_POLY5: begin cmd.poly5 = 1'b1; state_in = ST_POLY6; end
         ST_POLY6: begin cmd.poly6 = 1'b1; state_in = ST_POLY7; end
         ST_POLY7: begin cmd.poly7 = 1'b1; state_in = ST_OUT; end
         ST_OUT: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               if (sts.is_final) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (state_ff == ST_OUT)) else $error("emit outside output state");
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_CHECK)) else $error("load did not start check");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POLY7) |=> (state_ff == ST_OUT)) else $error("poly chain broken");
endmodule

// ===== hdl/fpps_div.sv =====
// radix-2 restoring divider: q = floor(t * 2^30 / l), one bit per cycle
// depends on fpps_pkg
module fpps_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] dividend,
   input  logic [23:0] divisor,
   output logic        done,
   output logic [55:0] quotient
);
   import fpps_pkg::*;

   logic [55:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [24:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[23:0], quo_ff[55]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd55;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[54:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[54:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd0);
   assign quotient = quo_in;
endmodule

// ===== hdl/fpps_dp.sv =====
// datapath: per-item registers, time step, quintic lateral evaluation, output stage
// depends on fpps_pkg and fpps_div
module fpps_dp #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [23:0]              csr_wdata,
   input  logic [158:0]             in_data,
   input  fpps_pkg::cmd_type        cmd,
   output fpps_pkg::sts_type        sts,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [68:0]              out_data,
   output logic                     out_last
);
   import fpps_pkg::*;

   localparam int unsigned KW = $clog2(MAX_POINTS + 1);

   logic [23:0] th_ff, lh_ff, si_ff;
   logic signed [31:0] s0_ff, d0_ff, vs_ff, vd_ff;
   logic [30:0] len_ff;
   logic [KW-1:0] k_ff;
   logic [33:0]   t_ff;
   logic signed [63:0] s_ff;
   logic [31:0] u_ff, a_ff, a2_ff, a3_ff, u2_ff, h0_ff, h1_ff, w_ff, ua3_ff;
   logic signed [63:0] latd_ff;
   logic signed [63:0] lat_ff;
   logic        zero_lat_ff;
   logic        ov_ff;
   logic [68:0] od_ff;
   logic        ol_ff;

   logic        div_done;
   logic [55:0] div_q;
   logic [33:0] t_next;
   logic signed [63:0] s_next;
   logic        stop_now;
   logic        nxt_stop;
   logic signed [31:0] lat_sat;

   fpps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({t_ff[25:0], 30'd0}),
      .divisor  (lh_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         th_ff <= 24'd655360;
         lh_ff <= 24'd327680;
         si_ff <= 24'd32768;
      end else if (csr_we) begin
         case (csr_index)
            RegTimeHorizon:    th_ff <= csr_wdata;
            RegLateralHorizon: lh_ff <= csr_wdata;
            RegSampleInterval: si_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign t_next = t_ff + {10'd0, si_ff};
   assign s_next = 64'(s0_ff) + 64'($signed($signed({{32{vs_ff[31]}}, vs_ff})
                 * $signed({30'd0, t_next})) >>> 16);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s0_ff  <= in_data[31:0];
         d0_ff  <= in_data[63:32];
         vs_ff  <= in_data[95:64];
         vd_ff  <= in_data[127:96];
         len_ff <= in_data[158:128];
         t_ff   <= '0;
         k_ff   <= '0;
      end else if (cmd.advance) begin
         t_ff <= t_next;
         k_ff <= k_ff + KW'(1);
      end
      if (cmd.load) s_ff <= $signed({{32{in_data[31]}}, in_data[31:0]});
      else if (cmd.advance) s_ff <= s_next;
      if (cmd.div_start) zero_lat_ff <= (t_ff > {10'd0, lh_ff});
      if (div_done) begin
         if (t_ff == '0 || lh_ff == '0) u_ff <= '0;
         else if (div_q > {24'd0, Q30One}) u_ff <= Q30One;
         else u_ff <= div_q[31:0];
      end
      if (cmd.poly1) begin
         a_ff  <= Q30One - u_ff;
         u2_ff <= 32'((64'(u_ff) * 64'(u_ff)) >> Q30Shift);
      end
      if (cmd.poly2) a2_ff <= 32'((64'(a_ff) * 64'(a_ff)) >> Q30Shift);
      if (cmd.poly3) a3_ff <= 32'((64'(a2_ff) * 64'(a_ff)) >> Q30Shift);
      if (cmd.poly4) begin
         h0_ff  <= 32'((64'(a3_ff) * (64'(Q30One) + 64'(u_ff) * 3 + 64'(u2_ff) * 6))
                   >> Q30Shift);
         ua3_ff <= 32'((64'(u_ff) * 64'(a3_ff)) >> Q30Shift);
      end
      if (cmd.poly5) begin
         h1_ff <= 32'((64'(ua3_ff) * (64'(Q30One) + 64'(u_ff) * 3)) >> Q30Shift);
      end
      // w scaled by lateral horizon, offset term from h0
      if (cmd.poly6) begin
         w_ff    <= 32'((64'(lh_ff) * 64'(h1_ff)) >> Q30Shift);
         latd_ff <= 64'((96'($signed(d0_ff)) * $signed({32'd0, h0_ff})) >>> Q30Shift);
      end
      if (cmd.poly7) begin
         lat_ff <= latd_ff + 64'((96'($signed(vd_ff)) * $signed({32'd0, w_ff})) >>> 16);
      end
   end

   always_comb begin
      if (zero_lat_ff) lat_sat = '0;
      else if (lat_ff > 64'sh7FFF_FFFF) lat_sat = 32'h7FFF_FFFF;
      else if (lat_ff < -64'sh8000_0000) lat_sat = 32'h8000_0000;
      else lat_sat = lat_ff[31:0];
   end

   assign stop_now = (t_ff > {10'd0, th_ff}) || (s_ff > $signed({33'd0, len_ff}))
                   || (k_ff == KW'(MAX_POINTS));

   assign nxt_stop = (t_next > {10'd0, th_ff})
                  || (s_next > $signed({33'd0, len_ff}))
                  || (k_ff + KW'(1) == KW'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (cmd.emit) begin
         ov_ff <= 1'b1;
      end else if (out_ready) begin
         ov_ff <= 1'b0;
      end
      if (cmd.emit) begin
         od_ff <= {lat_sat, (s_ff < 0) ? 31'd0 : s_ff[30:0], 6'(k_ff)};
         ol_ff <= nxt_stop;
      end
   end

   assign sts.stop     = stop_now;
   assign sts.is_final = nxt_stop;
   assign sts.div_done = div_done;
   assign sts.out_busy = ov_ff && !out_ready;
   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign out_last  = ol_ff;

   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> ov_ff) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(ov_ff && !out_ready)) else $error("result overwritten");
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stop_now) else $error("emit past end of run");
endmodule

// ===== hdl/frenet_polynomial_path_sampler.sv =====
// Frenet polynomial path sampler: per object, emits up to MAX_POINTS samples of
// along-path position and quintic lateral offset. Each sample passes through the
// check state, the serial divider forming t/L, seven multiply steps and the
// output state, which waits while the previous beat is unaccepted. An object is
// accepted only in the idle state, and one that yields no sample returns there
// from the check state; one object is processed at a time.
// depends on fpps_pkg, fpps_ctrl, fpps_dp, fpps_div
module frenet_polynomial_path_sampler #(
   parameter int unsigned MAX_POINTS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_along, start_across, speed_along, speed_across, path_length, pad
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sample_index, pos_along, pos_across, pad
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import fpps_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [68:0] od;

   fpps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   fpps_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_data   (req_tdata[158:0]),
      .cmd       (cmd),
      .sts       (sts),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (od),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, od};
endmodule

// ===== dv/tb_frenet_polynomial_path_sampler.sv =====
// self-checking testbench for the frenet polynomial path sampler
// predicts every sample beat from the object state and the timing registers
// depends on fpps_pkg and the frenet_polynomial_path_sampler rtl
module tb_frenet_polynomial_path_sampler;
   timeunit 1ns;
   timeprecision 1ps;
   import fpps_pkg::*;

   localparam int MaxPoints = 64;
   localparam int StallLimit = 200000;

   typedef struct packed {
      logic [30:0] path_length;
      logic [31:0] speed_across;
      logic [31:0] speed_along;
      logic [31:0] start_across;
      logic [31:0] start_along;
   } object_type;

   typedef struct packed {
      logic        last;
      logic [31:0] pos_across;
      logic [30:0] pos_along;
      logic [5:0]  sample_index;
   } sample_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 0;
   logic [1:0] csr_index = RegTimeHorizon;
   logic [23:0] csr_wdata = '0;

   logic [23:0] horizon_q, lat_horizon_q, interval_q;
   object_type pending_objects[$];
   sample_type expected_samples[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_off = 0;

   frenet_polynomial_path_sampler dut (.*);

   always #1 clock = ~clock;

   function automatic longint floor_shr(longint x, int sh);
      return x >>> sh;
   endfunction

   function automatic longint lateral_offset(longint unsigned t, longint d, longint v);
      longint unsigned lh, u, a, a3, u2, h0, h1, w;
      longint r;
      lh = lat_horizon_q;
      if (t > lh) return 0;
      u = (t == 0 || lh == 0) ? 0 : (t << 30) / lh;
      if (u > 64'd1 << 30) u = 64'd1 << 30;
      a = (64'd1 << 30) - u;
      a3 = (((a * a) >> 30) * a) >> 30;
      u2 = (u * u) >> 30;
      h0 = (a3 * ((64'd1 << 30) + 3 * u + 6 * u2)) >> 30;
      h1 = (((u * a3) >> 30) * ((64'd1 << 30) + 3 * u)) >> 30;
      w = (lh * h1) >> 30;
      r = floor_shr(d * longint'(h0), 30) + floor_shr(v * longint'(w), 16);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r;
   endfunction

   task automatic predict_samples(object_type obj);
      longint s0, d0, vs, vd, len, s;
      longint unsigned t;
      sample_type smp;
      int n;
      s0 = longint'(signed'(obj.start_along));
      d0 = longint'(signed'(obj.start_across));
      vs = longint'(signed'(obj.speed_along));
      vd = longint'(signed'(obj.speed_across));
      len = longint'(obj.path_length);
      n = 0;
      for (int k = 0; k < MaxPoints; k++) begin
         t = longint'(k) * interval_q;
         if (t > horizon_q) break;
         s = s0 + floor_shr(vs * longint'(t), 16);
         if (s > len) break;
         smp.sample_index = k[5:0];
         smp.pos_along = (s < 0) ? '0 : s[30:0];
         smp.pos_across = 32'(lateral_offset(t, d0, vd));
         smp.last = 0;
         expected_samples = {expected_samples, smp};
         n++;
      end
      if (n > 0) expected_samples[$].last = 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && req_tready) begin
         predict_samples(object_type'(req_tdata[158:0]));
         void'(pending_objects.pop_front());
         send_gap = $urandom_range(0, 13) * ($urandom_range(0, 3) == 0);
         if (pending_objects.size() > 0 && send_gap == 0) begin
            req_tdata <= {1'b0, pending_objects[0]};
         end else begin
            req_tvalid <= 0;
         end
      end else if (!req_tvalid && pending_objects.size() > 0) begin
         if (send_gap > 0) begin
            send_gap--;
         end else begin
            req_tvalid <= 1;
            req_tdata <= {1'b0, pending_objects[0]};
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sample_type got;
            sample_type want;
            got = {rsp_tlast, rsp_tdata[68:0]};
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected sample beat %h", got);
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sample mismatch: exp k=%0d s=%h d=%h l=%b got k=%0d s=%h d=%h l=%b",
                        want.sample_index, want.pos_along, want.pos_across, want.last,
                        got.sample_index, got.pos_along, got.pos_across, got.last);
               end
            end
            recv_gap = $urandom_range(0, 13) * ($urandom_range(0, 2) == 0);
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         RegTimeHorizon: horizon_q = val;
         RegLateralHorizon: lat_horizon_q = val;
         RegSampleInterval: interval_q = val;
         default: ;
      endcase
   endtask

   task automatic drain;
      while (pending_objects.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
         3: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_object(logic [31:0] sa, logic [31:0] sd, logic [31:0] va,
      logic [31:0] vd, logic [30:0] len);
      object_type o;
      o.start_along = sa;
      o.start_across = sd;
      o.speed_along = va;
      o.speed_across = vd;
      o.path_length = len;
      pending_objects = {pending_objects, o};
   endtask

   task automatic queue_random(int count);
      logic [30:0] len;
      for (int i = 0; i < count; i++) begin
         len = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 200 << 16));
         queue_object(($urandom_range(0, 5) == 0) ? rand_word() : $urandom_range(0, 50 << 16),
            rand_word(), ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 8 << 16),
            rand_word(), len);
      end
   endtask

   initial begin
      horizon_q = 24'd655360;
      lat_horizon_q = 24'd327680;
      interval_q = 24'd32768;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: field extremes at reset settings
      queue_object(32'd0, 32'd0, 32'd0, 32'd0, 31'd0);
      queue_object(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      queue_object(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
      queue_object(32'd100 << 16, 32'd1 << 16, 32'd0, 32'd0, 31'd10 << 16);
      queue_object(32'd0, 32'hfffe_0000, 32'd2 << 16, 32'h0001_8000, 31'd15 << 16);
      queue_object(32'hfff0_0000, 32'd3 << 16, 32'd5 << 16, 32'hffff_0000, 31'd100 << 16);
      queue_object(32'd5 << 16, 32'hffff_ffff, 32'hffff_ffff, 32'd1, 31'd5 << 16);
      drain();

      write_reg(RegTimeHorizon, 24'd0);
      write_reg(RegLateralHorizon, 24'd0);
      queue_object(32'd1 << 16, 32'd7 << 16, 32'd1 << 16, 32'd1 << 16, 31'd50 << 16);
      drain();
      write_reg(RegTimeHorizon, 24'hff_ffff);
      write_reg(RegSampleInterval, 24'd0);
      queue_object(32'd1 << 16, 32'hfff9_0000, 32'd1 << 16, 32'd1 << 16, 31'd50 << 16);
      drain();
      write_reg(RegSampleInterval, 24'hff_ffff);
      write_reg(RegLateralHorizon, 24'hff_ffff);
      queue_object(32'd0, 32'd7 << 16, 32'd0, 32'h7fff_ffff, 31'h7fff_ffff);
      queue_object(32'd0, 32'h8000_0000, 32'h0000_0100, 32'h8000_0000, 31'h7fff_ffff);
      drain();
      write_reg(RegSampleInterval, 24'd1);
      write_reg(RegLateralHorizon, 24'd1);
      queue_object(32'd0, 32'd7 << 16, 32'd1 << 16, 32'd3 << 16, 31'd9 << 16);
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(RegTimeHorizon, (ph == 5) ? 24'hff_ffff : 24'($urandom_range(1, 16 << 16)));
         write_reg(RegLateralHorizon, (ph == 4) ? 24'd1 : 24'($urandom_range(1, 12 << 16)));
         write_reg(RegSampleInterval, (ph == 3) ? 24'hff_ffff : 24'($urandom_range(1, 2 << 16)));
         queue_random(70);
         if (ph == 1) begin
            hold_off = 3000;
         end
         drain();
      end
      // register writes are 24 bits wide in the design; all values are reachable here
      write_reg(RegTimeHorizon, 24'd655360);
      write_reg(RegLateralHorizon, 24'd327680);
      write_reg(RegSampleInterval, 24'd131072);
      queue_random(40);
      drain();

      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
